FILE: hdl/c2dmac_pkg.sv
// Shared codes, constants and interface types of the convolution MAC core.
package c2dmac_pkg;

  // Function codes carried in s_tuser
  localparam logic [1:0] FUNC_WEIGHT  = 2'd0;
  localparam logic [1:0] FUNC_BIAS    = 2'd1;
  localparam logic [1:0] FUNC_PIXEL   = 2'd2;
  localparam logic [1:0] FUNC_COMPUTE = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_IN_CH  = 3'd0;
  localparam logic [2:0] REG_OUT_CH = 3'd1;
  localparam logic [2:0] REG_KERNEL = 3'd2;
  localparam logic [2:0] REG_STRIDE = 3'd3;
  localparam logic [2:0] REG_PAD    = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;
  localparam logic [2:0] REG_WIDTH  = 3'd6;

  localparam int MAX_STRIDE = 8;

  // Cycles from the last tap issue until the accumulator holds the full sum
  localparam int DRAIN_CYCLES = 2;

  // Clamped geometry as used by the compute path
  typedef struct packed {
    logic [2:0] nin;
    logic [4:0] nout;
    logic [3:0] k;
    logic [3:0] s;
    logic [2:0] p;
    logic [5:0] h;
    logic [5:0] w;
  } geom_t;

  // Controller to datapath
  typedef struct packed {
    logic       accept;
    logic       clear;
    logic       issue;
    logic [3:0] tap_row;
    logic [3:0] tap_col;
    logic [2:0] tap_ch;
    logic       finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pos_err;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/c2dmac_cfg.sv
// Configuration register file with range clamping of the geometry.
module c2dmac_cfg
  import c2dmac_pkg::*;
#(
  parameter int MAX_IN_CH  = 4,
  parameter int MAX_OUT_CH = 16,
  parameter int MAX_KERNEL = 8,
  parameter int MAX_DIM    = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [5:0] cfg_data,
  output geom_t      geom
);

  logic [2:0] in_ch;
  logic [4:0] out_ch;
  logic [3:0] kernel;
  logic [3:0] stride;
  logic [2:0] pad;
  logic [5:0] height;
  logic [5:0] width;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_ch  <= 3'd3;
      out_ch <= 5'd16;
      kernel <= 4'd4;
      stride <= 4'd4;
      pad    <= 3'd0;
      height <= 6'd32;
      width  <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_CH:  in_ch  <= cfg_data[2:0];
        REG_OUT_CH: out_ch <= cfg_data[4:0];
        REG_KERNEL: kernel <= cfg_data[3:0];
        REG_STRIDE: stride <= cfg_data[3:0];
        REG_PAD:    pad    <= cfg_data[2:0];
        REG_HEIGHT: height <= cfg_data[5:0];
        REG_WIDTH:  width  <= cfg_data[5:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // Clamp each register but the pad into its legal range
  always_comb begin
    geom.nin  = (in_ch == 3'd0) ? 3'd1 :
                ((32'(in_ch) > MAX_IN_CH) ? 3'(MAX_IN_CH) : in_ch);
    geom.nout = (out_ch == 5'd0) ? 5'd1 :
                ((32'(out_ch) > MAX_OUT_CH) ? 5'(MAX_OUT_CH) : out_ch);
    geom.k    = (kernel == 4'd0) ? 4'd1 :
                ((32'(kernel) > MAX_KERNEL) ? 4'(MAX_KERNEL) : kernel);
    geom.s    = (stride == 4'd0) ? 4'd1 :
                ((32'(stride) > MAX_STRIDE) ? 4'(MAX_STRIDE) : stride);
    geom.p    = pad;
    geom.h    = (height == 6'd0) ? 6'd1 :
                ((32'(height) > MAX_DIM) ? 6'(MAX_DIM) : height);
    geom.w    = (width == 6'd0) ? 6'd1 :
                ((32'(width) > MAX_DIM) ? 6'(MAX_DIM) : width);
  end

endmodule

FILE: hdl/c2dmac_ctrl.sv
// Controller: item intake, tap sequencing over kernel and channels, drain and result hand-off.
module c2dmac_ctrl
  import c2dmac_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic [1:0] func,
  input  geom_t      geom,
  input  status_t    status,
  output logic       s_tready,
  output cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [3:0] tap_row, tap_row_next;
  logic [3:0] tap_col, tap_col_next;
  logic [2:0] tap_ch, tap_ch_next;
  logic [1:0] drain_cnt, drain_cnt_next;
  logic       in_fire;
  logic       ch_last, col_last, row_last;

  assign ch_last  = (tap_ch == geom.nin - 3'd1);
  assign col_last = (tap_col == geom.k - 4'd1);
  assign row_last = (tap_row == geom.k - 4'd1);

  always_comb begin
    state_next     = state;
    tap_row_next   = tap_row;
    tap_col_next   = tap_col;
    tap_ch_next    = tap_ch;
    drain_cnt_next = drain_cnt;
    s_tready       = (state == S_IDLE);
    in_fire        = s_tvalid && s_tready;
    cmd            = '0;
    cmd.accept     = in_fire;
    cmd.tap_row    = tap_row;
    cmd.tap_col    = tap_col;
    cmd.tap_ch     = tap_ch;
    unique case (state)
      S_IDLE: begin
        if (in_fire && func == FUNC_COMPUTE) state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.clear    = 1'b1;
        tap_row_next = 4'd0;
        tap_col_next = 4'd0;
        tap_ch_next  = 3'd0;
        state_next   = S_RUN;
      end
      S_RUN: begin
        drain_cnt_next = 2'd0;
        if (status.pos_err) begin
          state_next = S_DRAIN;
        end else begin
          cmd.issue = 1'b1;
          // advance channel, then column, then row
          if (ch_last) begin
            tap_ch_next = 3'd0;
            if (col_last) begin
              tap_col_next = 4'd0;
              tap_row_next = tap_row + 4'd1;
            end else begin
              tap_col_next = tap_col + 4'd1;
            end
          end else begin
            tap_ch_next = tap_ch + 3'd1;
          end
          if (ch_last && col_last && row_last) state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_cnt == 2'(DRAIN_CYCLES - 1)) begin
          state_next = S_DONE;
        end else begin
          drain_cnt_next = drain_cnt + 2'd1;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_row   <= 4'd0;
      tap_col   <= 4'd0;
      tap_ch    <= 3'd0;
      drain_cnt <= 2'd0;
    end else begin
      state     <= state_next;
      tap_row   <= tap_row_next;
      tap_col   <= tap_col_next;
      tap_ch    <= tap_ch_next;
      drain_cnt <= drain_cnt_next;
    end
  end

  a_no_issue_on_error: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !status.pos_err)
    else $error("tap issued for a position outside the output map");

  a_finish_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("result loaded while the output register is occupied");

  a_done_after_drain: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> $past(state) == S_DRAIN || $past(state) == S_DONE)
    else $error("result stage entered without draining the MAC pipeline");

  a_taps_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> tap_ch < geom.nin && tap_col < geom.k && tap_row < geom.k)
    else $error("tap counter beyond kernel or channel count");

endmodule

FILE: hdl/c2dmac_dp.sv
// Datapath: weight, bias and pixel stores, tap addressing, MAC pipeline and output register.
module c2dmac_dp
  import c2dmac_pkg::*;
#(
  parameter int MAX_IN_CH  = 4,
  parameter int MAX_OUT_CH = 16,
  parameter int MAX_KERNEL = 8,
  parameter int MAX_DIM    = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  geom_t              geom,
  input  logic [1:0]         func,
  input  logic [3:0]         out_channel,
  input  logic [1:0]         in_channel,
  input  logic [4:0]         row,
  input  logic [4:0]         col,
  input  logic signed [15:0] value,
  input  logic               m_tready,
  output status_t            status,
  output logic               m_tvalid,
  output logic signed [15:0] result_value,
  output logic               position_error
);

  localparam int CW     = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
  localparam int OCW    = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int KW     = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int DW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int PIX_AW = CW + 2 * DW;
  localparam int WT_AW  = OCW + CW + 2 * KW;
  localparam int ACC_W  = 33 + $clog2(MAX_KERNEL * MAX_KERNEL * MAX_IN_CH);

  logic signed [15:0] pix_mem  [2**PIX_AW];
  logic signed [15:0] wt_mem   [2**WT_AW];
  logic signed [15:0] bias_mem [2**OCW];

  logic                    wr_weight, wr_bias, wr_pixel;
  logic [PIX_AW-1:0]       pix_waddr, pix_raddr;
  logic [WT_AW-1:0]        wt_waddr, wt_raddr;
  logic signed [15:0]      pix_q, wt_q, bias_q;
  logic [3:0]              oc_q;
  logic [4:0]              row_q, col_q;
  logic [8:0]              row_s, col_s;
  logic                    row_fit, col_fit, pos_err, pos_err_next;
  logic signed [10:0]      base_h, base_w, ih, iw;
  logic                    tap_in;
  logic                    valid_a, valid_b;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc, res_full;
  logic signed [15:0]      sat_val;

  // Store writes, guarded against the store capacity
  assign wr_weight = cmd.accept && func == FUNC_WEIGHT && 32'(out_channel) < MAX_OUT_CH &&
                     32'(in_channel) < MAX_IN_CH && 32'(row) < MAX_KERNEL &&
                     32'(col) < MAX_KERNEL;
  assign wr_bias   = cmd.accept && func == FUNC_BIAS && 32'(out_channel) < MAX_OUT_CH;
  assign wr_pixel  = cmd.accept && func == FUNC_PIXEL && 32'(in_channel) < MAX_IN_CH &&
                     32'(row) < MAX_DIM && 32'(col) < MAX_DIM;

  assign wt_waddr  = {OCW'(out_channel), CW'(in_channel), KW'(row), KW'(col)};
  assign pix_waddr = {CW'(in_channel), DW'(row), DW'(col)};

  // Position check: oc below nout, row/col * stride + kernel within padded height/width
  assign row_s   = 9'(row_q) * 9'(geom.s);
  assign col_s   = 9'(col_q) * 9'(geom.s);
  assign row_fit = ({1'b0, row_s} + 10'(geom.k)) <= (10'(geom.h) + 10'({geom.p, 1'b0}));
  assign col_fit = ({1'b0, col_s} + 10'(geom.k)) <= (10'(geom.w) + 10'({geom.p, 1'b0}));
  assign pos_err_next = ({1'b0, oc_q} >= geom.nout) || !row_fit || !col_fit;

  // Tap address; taps in the padding border are dropped
  assign ih     = base_h + $signed({7'b0, cmd.tap_row});
  assign iw     = base_w + $signed({7'b0, cmd.tap_col});
  assign tap_in = !ih[10] && !iw[10] && (ih[9:0] < 10'(geom.h)) && (iw[9:0] < 10'(geom.w));

  assign pix_raddr = {CW'(cmd.tap_ch), DW'(ih[9:0]), DW'(iw[9:0])};
  assign wt_raddr  = {OCW'(oc_q), CW'(cmd.tap_ch), KW'(cmd.tap_row), KW'(cmd.tap_col)};

  always_ff @(posedge clk) begin
    if (wr_pixel) pix_mem[pix_waddr] <= value;
    pix_q <= pix_mem[pix_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_weight) wt_mem[wt_waddr] <= value;
    wt_q <= wt_mem[wt_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_bias) bias_mem[OCW'(out_channel)] <= value;
    bias_q <= bias_mem[OCW'(oc_q)];
  end

  // Compute item capture and per-item setup
  always_ff @(posedge clk) begin
    if (cmd.accept && func == FUNC_COMPUTE) begin
      oc_q  <= out_channel;
      row_q <= row;
      col_q <= col;
    end
    if (cmd.clear) begin
      base_h <= $signed({2'b00, row_s}) - $signed({8'b0, geom.p});
      base_w <= $signed({2'b00, col_s}) - $signed({8'b0, geom.p});
    end
  end

  // MAC pipeline: memory read, multiply, accumulate
  always_ff @(posedge clk) begin
    prod <= pix_q * wt_q;
    if (cmd.clear) begin
      acc <= '0;
    end else if (valid_b) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      pos_err <= 1'b0;
    end else begin
      valid_a <= cmd.issue && tap_in;
      valid_b <= valid_a;
      if (cmd.clear) pos_err <= pos_err_next;
    end
  end

  // floor(acc / 256) plus bias, saturated to Q8.8
  assign res_full = (acc >>> 8) + ACC_W'(bias_q);

  always_comb begin
    if (res_full > ACC_W'(32767)) begin
      sat_val = 16'sh7fff;
    end else if (res_full < ACC_W'(-32768)) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = 16'(res_full);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result_value   <= pos_err ? 16'sd0 : sat_val;
      position_error <= pos_err;
    end
  end

  assign status.pos_err  = pos_err;
  assign status.out_free = !m_tvalid || m_tready;

  a_error_value_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && position_error |-> result_value == 16'sd0)
    else $error("position error result carries a nonzero value");

  a_finish_loads_output: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid)
    else $error("finished result not presented");

  a_pipeline_empty_at_setup: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !valid_a && !valid_b)
    else $error("MAC pipeline still busy when a new sum starts");

endmodule

FILE: hdl/conv2d_forward_mac_core.sv
// A compute item passes from idle through setup, run (one MAC per cycle over K*K*C taps, K
// kernel side, C input channels in use; no tap if outside the output map), drain and done,
// where it waits for a free output register; no item is taken until it is back in idle.
// Store write items are taken while idle, one per cycle.
// Reset (synchronous, active high) restores the registers to 3,16,4,4,0,32,32 and clears
// control; the stores are not cleared and hold nothing defined until written.
module conv2d_forward_mac_core
  import c2dmac_pkg::*;
#(
  parameter int MAX_IN_CH  = 4,
  parameter int MAX_OUT_CH = 16,
  parameter int MAX_KERNEL = 8,
  parameter int MAX_DIM    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // out_channel[3:0], in_channel[5:4], row[10:6],
                                 // col[15:11], value[31:16]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // result_value[15:0]
  output logic        m_tuser,   // position_error
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  geom_t              geom;
  cmd_t               cmd;
  status_t            status;
  logic signed [15:0] result_value;

  c2dmac_cfg #(
    .MAX_IN_CH (MAX_IN_CH),
    .MAX_OUT_CH(MAX_OUT_CH),
    .MAX_KERNEL(MAX_KERNEL),
    .MAX_DIM   (MAX_DIM)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .geom     (geom)
  );

  c2dmac_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .func    (s_tuser),
    .geom    (geom),
    .status  (status),
    .s_tready(s_tready),
    .cmd     (cmd)
  );

  c2dmac_dp #(
    .MAX_IN_CH (MAX_IN_CH),
    .MAX_OUT_CH(MAX_OUT_CH),
    .MAX_KERNEL(MAX_KERNEL),
    .MAX_DIM   (MAX_DIM)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .geom          (geom),
    .func          (s_tuser),
    .out_channel   (s_tdata[3:0]),
    .in_channel    (s_tdata[5:4]),
    .row           (s_tdata[10:6]),
    .col           (s_tdata[15:11]),
    .value         (s_tdata[31:16]),
    .m_tready      (m_tready),
    .status        (status),
    .m_tvalid      (m_tvalid),
    .result_value  (result_value),
    .position_error(m_tuser)
  );

  assign m_tdata = result_value;

endmodule

FILE: test/conv2d_forward_mac_core_test.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the convolution MAC core with its own Q8.8 predictor.
module conv2d_forward_mac_core_test
  import c2dmac_pkg::*;
();

  localparam int IN_CH_CAP   = 4;
  localparam int OUT_CH_CAP  = 16;
  localparam int KERNEL_CAP  = 8;
  localparam int DIM_CAP     = 32;
  localparam int PHASE_COUNT = 10;
  localparam int PHASE_ITEMS = 125;
  // Bound for ~1400 items even if each is a compute, stalls on top
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int CFG_BITS [0:6] = '{3, 5, 4, 4, 3, 6, 6};
  // Raw register values per phase; later phases draw them at random
  localparam int FIXED_SETTINGS [0:6][0:6] = '{
    '{1, 1, 1, 1, 0, 1, 1},
    '{3, 16, 4, 4, 0, 32, 32},
    '{4, 16, 8, 8, 7, 32, 32},
    '{0, 0, 0, 0, 0, 0, 0},
    '{7, 31, 15, 15, 7, 63, 63},
    '{2, 8, 8, 1, 0, 5, 7},
    '{2, 5, 3, 2, 1, 16, 12}
  };

  typedef struct {
    logic [1:0]  func;
    logic [3:0]  oc;
    logic [1:0]  ic;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [15:0] value;
  } conv_item_t;

  typedef struct {
    logic [15:0] value;
    logic        pos_err;
  } conv_out_t;

  typedef struct {
    int nin, nout, k, s, p, h, w, oh, ow;
  } conv_shape_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // out_channel[3:0], in_channel[5:4], row[10:6],
                               // col[15:11], value[31:16]
  logic [1:0]  s_tuser = '0;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // result_value[15:0]
  logic        m_tuser;        // position_error
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [5:0]  cfg_data = '0;

  conv2d_forward_mac_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor copy of the registers and stores
  logic [5:0]        cfg_shadow [0:6] = '{6'd3, 6'd16, 6'd4, 6'd4, 6'd0, 6'd32, 6'd32};
  logic signed [15:0] pix_mem  [IN_CH_CAP][DIM_CAP][DIM_CAP];
  logic signed [15:0] wgt_mem  [OUT_CH_CAP][IN_CH_CAP][KERNEL_CAP][KERNEL_CAP];
  logic signed [15:0] bias_mem [OUT_CH_CAP];

  // Entries already loaded by queued items, so no compute reads an unwritten one
  bit pix_set  [IN_CH_CAP][DIM_CAP][DIM_CAP];
  bit wgt_set  [OUT_CH_CAP][IN_CH_CAP][KERNEL_CAP][KERNEL_CAP];
  bit bias_set [OUT_CH_CAP];

  conv_item_t pending_q [$];
  conv_out_t  expected_q [$];
  conv_item_t next_item;
  conv_out_t  want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int queued_count = 0;
  int accepted_count = 0;
  int phase_items = 0;
  int results_checked = 0;
  int border_results = 0;
  int fail_count = 0;
  int cycle_count = 0;
  logic in_taken = 1'b0;

  int          in_oc, in_ic, in_row, in_col;
  logic [15:0] in_val;

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic conv_shape_t shape_of();
    conv_shape_t g;
    g.nin  = clip(int'(cfg_shadow[REG_IN_CH]), 1, IN_CH_CAP);
    g.nout = clip(int'(cfg_shadow[REG_OUT_CH]), 1, OUT_CH_CAP);
    g.k    = clip(int'(cfg_shadow[REG_KERNEL]), 1, KERNEL_CAP);
    g.s    = clip(int'(cfg_shadow[REG_STRIDE]), 1, MAX_STRIDE);
    g.p    = int'(cfg_shadow[REG_PAD]);
    g.h    = clip(int'(cfg_shadow[REG_HEIGHT]), 1, DIM_CAP);
    g.w    = clip(int'(cfg_shadow[REG_WIDTH]), 1, DIM_CAP);
    g.oh   = (g.h + 2 * g.p >= g.k) ? (g.h + 2 * g.p - g.k) / g.s + 1 : 0;
    g.ow   = (g.w + 2 * g.p >= g.k) ? (g.w + 2 * g.p - g.k) / g.s + 1 : 0;
    return g;
  endfunction

  // Window sum plus bias, floor to Q8.8 and saturate
  function automatic conv_out_t predict_output(int oc, int row, int col);
    conv_shape_t g;
    conv_out_t   r;
    longint      acc;
    int          i, j, c, ih, iw;
    g = shape_of();
    r.value = '0;
    r.pos_err = 1'b1;
    if (oc < g.nout && row < g.oh && col < g.ow) begin
      acc = 0;
      for (i = 0; i < g.k; i++) begin
        for (j = 0; j < g.k; j++) begin
          ih = row * g.s + i - g.p;
          iw = col * g.s + j - g.p;
          if (ih >= 0 && ih < g.h && iw >= 0 && iw < g.w) begin
            for (c = 0; c < g.nin; c++)
              acc += longint'(pix_mem[c][ih][iw]) * longint'(wgt_mem[oc][c][i][j]);
          end
        end
      end
      acc += longint'(bias_mem[oc]) * 256;
      acc = acc >>> 8;
      if (acc > 32767) acc = 32767;
      else if (acc < -32768) acc = -32768;
      r.value = acc[15:0];
      r.pos_err = 1'b0;
    end
    return r;
  endfunction

  // Count the load items a compute still needs before it can be queued
  function automatic int window_loads(int oc, int row, int col);
    conv_shape_t g;
    int          i, j, c, ih, iw, n;
    g = shape_of();
    n = 0;
    if (oc < g.nout && row < g.oh && col < g.ow) begin
      for (i = 0; i < g.k; i++) begin
        for (j = 0; j < g.k; j++) begin
          ih = row * g.s + i - g.p;
          iw = col * g.s + j - g.p;
          if (ih >= 0 && ih < g.h && iw >= 0 && iw < g.w) begin
            for (c = 0; c < g.nin; c++) begin
              if (!pix_set[c][ih][iw]) n++;
              if (!wgt_set[oc][c][i][j]) n++;
            end
          end
        end
      end
      if (!bias_set[oc]) n++;
    end
    return n;
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom());
      default: return 16'($urandom_range(2047)) - 16'd1024;
    endcase
  endfunction

  task automatic queue_item(logic [1:0] func, int oc, int ic, int row, int col,
                            logic [15:0] value);
    conv_item_t it;
    it.func = func;
    it.oc = 4'(oc);
    it.ic = 2'(ic);
    it.row = 5'(row);
    it.col = 5'(col);
    it.value = value;
    pending_q.push_back(it);
    queued_count++;
    // Weight writes past the kernel store are dropped by the block
    if (!(func == FUNC_WEIGHT && (row >= KERNEL_CAP || col >= KERNEL_CAP))) begin
      phase_items++;
      case (func)
        FUNC_WEIGHT: wgt_set[oc][ic][row][col] = 1'b1;
        FUNC_BIAS:   bias_set[oc] = 1'b1;
        FUNC_PIXEL:  pix_set[ic][row][col] = 1'b1;
        default:     ;
      endcase
    end
  endtask

  // Load whatever the window still lacks, then queue the compute itself
  task automatic queue_compute(int oc, int row, int col);
    conv_shape_t g;
    int          i, j, c, ih, iw;
    g = shape_of();
    if (oc < g.nout && row < g.oh && col < g.ow) begin
      for (i = 0; i < g.k; i++) begin
        for (j = 0; j < g.k; j++) begin
          ih = row * g.s + i - g.p;
          iw = col * g.s + j - g.p;
          if (ih >= 0 && ih < g.h && iw >= 0 && iw < g.w) begin
            for (c = 0; c < g.nin; c++) begin
              if (!pix_set[c][ih][iw])
                queue_item(FUNC_PIXEL, $urandom_range(15), c, ih, iw, rand_value());
              if (!wgt_set[oc][c][i][j])
                queue_item(FUNC_WEIGHT, oc, c, i, j, rand_value());
            end
          end
        end
      end
      if (!bias_set[oc])
        queue_item(FUNC_BIAS, oc, $urandom_range(3), $urandom_range(31),
                   $urandom_range(31), rand_value());
    end
    queue_item(FUNC_COMPUTE, oc, $urandom_range(3), row, col, 16'($urandom()));
  endtask

  task automatic drain_pipeline();
    while (accepted_count != queued_count || expected_q.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Driver: present the next item once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || in_taken) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {next_item.value, next_item.col, next_item.row, next_item.ic,
                      next_item.oc};
          s_tuser <= next_item.func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: update the predictor on each accepted item, check each result
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        accepted_count++;
        in_oc  = int'(s_tdata[3:0]);
        in_ic  = int'(s_tdata[5:4]);
        in_row = int'(s_tdata[10:6]);
        in_col = int'(s_tdata[15:11]);
        in_val = s_tdata[31:16];
        case (s_tuser)
          FUNC_WEIGHT: begin
            if (in_row < KERNEL_CAP && in_col < KERNEL_CAP)
              wgt_mem[in_oc][in_ic][in_row][in_col] = in_val;
          end
          FUNC_BIAS:  bias_mem[in_oc] = in_val;
          FUNC_PIXEL: pix_mem[in_ic][in_row][in_col] = in_val;
          default:    expected_q.push_back(predict_output(in_oc, in_row, in_col));
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: result_value %h position_error %b", m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          results_checked++;
          if (want.pos_err) border_results++;
          if (m_tdata !== want.value) begin
            $error("result_value mismatch: expected %h actual %h", want.value, m_tdata);
            fail_count++;
          end
          if (m_tuser !== want.pos_err) begin
            $error("position_error mismatch: expected %b actual %b", want.pos_err, m_tuser);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timed out with %0d results outstanding", expected_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int          ph, r, pick, row_top, col_top;
    int          pick_oc, pick_row, pick_col;
    int          regs_now [0:6];
    conv_shape_t g;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry gives an 8x8 output map
    queue_compute(15, 8, 0);
    queue_compute(15, 7, 31);
    queue_compute(15, 7, 7);
    drain_pipeline();

    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph < 7)
        regs_now = FIXED_SETTINGS[ph];
      else
        regs_now = '{$urandom_range(7), $urandom_range(31), $urandom_range(15),
                     $urandom_range(15), $urandom_range(7), $urandom_range(63),
                     $urandom_range(63)};
      for (r = REG_IN_CH; r <= REG_WIDTH; r++) begin
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= 3'(r);
        cfg_data <= 6'(regs_now[r]);
        cfg_shadow[r] = 6'(regs_now[r]) & 6'((1 << CFG_BITS[r]) - 1);
      end
      // An unknown index must leave every register alone
      if (ph == 3) begin
        @(negedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data <= 6'h3F;
      end
      @(negedge clk);
      cfg_we <= 1'b0;

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      @(posedge clk);

      if (ph == 0) begin
        // Single tap, single channel: exercise saturation and floor rounding
        queue_item(FUNC_WEIGHT, 0, 0, 0, 0, 16'h7FFF);
        queue_item(FUNC_PIXEL, 9, 0, 0, 0, 16'h7FFF);
        queue_item(FUNC_BIAS, 0, 0, 0, 0, 16'h0000);
        queue_compute(0, 0, 0);
        queue_item(FUNC_PIXEL, 0, 0, 0, 0, 16'h8000);
        queue_compute(0, 0, 0);
        queue_item(FUNC_WEIGHT, 0, 0, 0, 0, 16'h8000);
        queue_compute(0, 0, 0);
        queue_item(FUNC_WEIGHT, 0, 0, 0, 0, 16'h0180);
        queue_item(FUNC_WEIGHT, 0, 0, 8, 0, 16'h5A5A);
        queue_item(FUNC_WEIGHT, 0, 0, 0, 24, 16'hA5A5);
        queue_item(FUNC_PIXEL, 0, 0, 0, 0, 16'hFF01);
        queue_item(FUNC_BIAS, 0, 0, 0, 0, 16'hFF00);
        queue_compute(0, 0, 0);
        queue_item(FUNC_WEIGHT, 0, 0, 0, 0, 16'h0000);
        queue_item(FUNC_BIAS, 0, 0, 0, 0, 16'h7FFF);
        queue_compute(0, 0, 0);
        queue_compute(15, 0, 0);
        queue_compute(0, 31, 0);
        queue_compute(0, 0, 31);
        queue_item(FUNC_WEIGHT, 15, 3, 7, 7, 16'h7FFF);
        queue_item(FUNC_PIXEL, 15, 3, 31, 31, 16'h8000);
        queue_item(FUNC_BIAS, 15, 3, 31, 31, 16'h8000);
      end

      g = shape_of();
      row_top = ((g.oh < DIM_CAP) ? g.oh : DIM_CAP) - 1;
      col_top = ((g.ow < DIM_CAP) ? g.ow : DIM_CAP) - 1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          if (pick < 45 && row_top >= 0 && col_top >= 0) begin
            pick_oc  = $urandom_range(g.nout - 1);
            pick_row = $urandom_range(row_top);
            pick_col = $urandom_range(col_top);
          end else begin
            pick_oc  = $urandom_range(15);
            pick_row = $urandom_range(31);
            pick_col = $urandom_range(31);
          end
          // Skip a window whose loads would overrun what is left of the phase
          if (window_loads(pick_oc, pick_row, pick_col) < PHASE_ITEMS - phase_items)
            queue_compute(pick_oc, pick_row, pick_col);
        end else if (pick < 70) begin
          if ($urandom_range(4) != 0)
            queue_item(FUNC_PIXEL, $urandom_range(15), $urandom_range(g.nin - 1),
                       $urandom_range(g.h - 1), $urandom_range(g.w - 1), rand_value());
          else
            queue_item(FUNC_PIXEL, $urandom_range(15), $urandom_range(3),
                       $urandom_range(31), $urandom_range(31), rand_value());
        end else if (pick < 88) begin
          if ($urandom_range(5) != 0)
            queue_item(FUNC_WEIGHT, $urandom_range(g.nout - 1), $urandom_range(g.nin - 1),
                       $urandom_range(g.k - 1), $urandom_range(g.k - 1), rand_value());
          else
            queue_item(FUNC_WEIGHT, $urandom_range(15), $urandom_range(3),
                       $urandom_range(31), $urandom_range(31), rand_value());
        end else begin
          queue_item(FUNC_BIAS, $urandom_range(15), $urandom_range(3),
                     $urandom_range(31), $urandom_range(31), rand_value());
        end
      end
      drain_pipeline();
    end

    $display("Checked %0d results (%0d flagged outside the output map) from %0d items,",
             results_checked, border_results, accepted_count);
    $display("over %0d register settings and four pacing modes on both stream sides.",
             PHASE_COUNT + 1);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
hdl/c2dmac_pkg.sv
hdl/c2dmac_cfg.sv
hdl/c2dmac_ctrl.sv
hdl/c2dmac_dp.sv
hdl/conv2d_forward_mac_core.sv
test/conv2d_forward_mac_core_test.sv
